@@ sv/wpsp_pkg.sv @@
// Shared types and constants for the RIFF/WAVE PCM parser.
package wpsp_pkg;
  localparam logic [3:0] PH_RIFF  = 4'd0;
  localparam logic [3:0] PH_RSIZE = 4'd1;
  localparam logic [3:0] PH_WAVE  = 4'd2;
  localparam logic [3:0] PH_CID   = 4'd3;
  localparam logic [3:0] PH_CSIZE = 4'd4;
  localparam logic [3:0] PH_FMT   = 4'd5;
  localparam logic [3:0] PH_DATA  = 4'd6;
  localparam logic [3:0] PH_SKIP  = 4'd7;

  localparam logic [1:0] CT_OTHER = 2'd0;
  localparam logic [1:0] CT_FMT   = 2'd1;
  localparam logic [1:0] CT_DATA  = 2'd2;

  localparam logic [2:0] ERR_RIFF  = 3'd0;
  localparam logic [2:0] ERR_RSIZE = 3'd1;
  localparam logic [2:0] ERR_WAVE  = 3'd2;
  localparam logic [2:0] ERR_FSIZE = 3'd3;
  localparam logic [2:0] ERR_EXT   = 3'd4;
  localparam logic [2:0] ERR_NOFMT = 3'd5;
  localparam logic [2:0] ERR_PCM   = 3'd6;
  localparam logic [2:0] ERR_BITS  = 3'd7;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  // classified item passed from front to back
  typedef struct packed {
    logic        is_err;
    logic        clear;    // restart statistics
    logic [2:0]  code;
    logic        wide;     // 16-bit sample
    logic [15:0] raw;
    logic [15:0] chan;
  } op_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  error_code;
    logic [15:0] sample_raw;
    logic [15:0] channel;
    logic [31:0] sample_count;
    logic [15:0] signed_min;
    logic [15:0] signed_max;
    logic [15:0] unsigned_min;
    logic [15:0] unsigned_max;
    logic [47:0] signed_total;
    logic [47:0] unsigned_total;
  } res_t;

  function automatic logic [7:0] riff_byte(input logic [1:0] i);
    case (i)
      2'd0:    riff_byte = 8'h52;
      2'd1:    riff_byte = 8'h49;
      default: riff_byte = 8'h46;
    endcase
  endfunction

  function automatic logic [7:0] wave_byte(input logic [1:0] i);
    case (i)
      2'd0:    wave_byte = 8'h57;
      2'd1:    wave_byte = 8'h41;
      2'd2:    wave_byte = 8'h56;
      default: wave_byte = 8'h45;
    endcase
  endfunction

  function automatic logic [7:0] id_byte(input logic [1:0] ct, input logic [1:0] i);
    logic [31:0] w;
    w = (ct == CT_FMT) ? 32'h20746D66 : (ct == CT_DATA) ? 32'h61746164 : 32'h0;
    id_byte = w[{i, 3'b000} +: 8];
  endfunction
endpackage

@@ sv/wpsp_front.sv @@
// Front end: byte-level RIFF/WAVE parse, emits classified ops.
module wpsp_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [7:0]      in_byte,
  output logic            in_ready,
  output logic            op_valid,
  output wpsp_pkg::op_t   op,
  input  logic            op_room
);
  logic [3:0]  phase_r, phase_nxt;
  logic [4:0]  idx_r, idx_nxt;     // byte index, fmt offsets saturate at 31
  logic [1:0]  ct_r, ct_nxt;
  logic        fseen_r, fseen_nxt;
  logic [15:0] tag_r, tag_nxt, nch_r, nch_nxt, bits_r, bits_nxt, bb_r, bb_nxt;
  logic [15:0] bpos_r, bpos_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic        halt_r, halt_nxt;
  logic        clr_r, clr_nxt;     // next sample op restarts statistics
  logic [17:0] span_r, span_nxt;   // channel_total * bytes per sample

  logic [1:0]  i;
  logic        go;
  logic [31:0] rem_dec, rem_new;
  logic [16:0] bpos_inc;
  logic [17:0] span_now;
  logic        e;
  logic [2:0]  ec;
  logic        s;
  logic [15:0] sraw, schan;

  // once halted every item is taken and dropped
  assign in_ready = op_room || halt_r;
  assign go = in_valid && in_ready;
  assign i = idx_r[1:0];
  assign rem_dec = (rem_r != 32'd0) ? rem_r - 32'd1 : rem_r;
  assign rem_new = rem_r | ({24'd0, in_byte} << {i, 3'b000});
  assign bpos_inc = {1'b0, bpos_r} + 17'd1;
  assign span_now = (bits_r == 16'd16) ? {1'b0, nch_r, 1'b0} :
                    (bits_r == 16'd8) ? {2'b00, nch_r} : 18'h3FFFF;

  always_comb begin
    phase_nxt = phase_r; idx_nxt = idx_r; ct_nxt = ct_r; fseen_nxt = fseen_r;
    tag_nxt = tag_r; nch_nxt = nch_r; bits_nxt = bits_r; bb_nxt = bb_r;
    bpos_nxt = bpos_r; rem_nxt = rem_r; hold_nxt = hold_r; halt_nxt = halt_r;
    clr_nxt = clr_r; span_nxt = span_r;
    e = 1'b0; ec = wpsp_pkg::ERR_RIFF; s = 1'b0; sraw = 16'd0; schan = 16'd0;
    if (go && !halt_r) begin
      case (phase_r)
        wpsp_pkg::PH_RIFF, wpsp_pkg::PH_WAVE: begin
          if (in_byte != ((phase_r == wpsp_pkg::PH_RIFF) ? wpsp_pkg::riff_byte(i)
                                                         : wpsp_pkg::wave_byte(i))) begin
            e = 1'b1;
            ec = (phase_r == wpsp_pkg::PH_RIFF) ? wpsp_pkg::ERR_RIFF : wpsp_pkg::ERR_WAVE;
          end else begin
            idx_nxt = {3'd0, i} + 5'd1;
            if (i == 2'd3) begin
              idx_nxt = 5'd0;
              if (phase_r == wpsp_pkg::PH_RIFF) begin
                phase_nxt = wpsp_pkg::PH_RSIZE; rem_nxt = 32'd0;
              end else begin
                phase_nxt = wpsp_pkg::PH_CID;
              end
            end
          end
        end
        wpsp_pkg::PH_RSIZE, wpsp_pkg::PH_CSIZE: begin
          rem_nxt = rem_new;
          idx_nxt = {3'd0, i} + 5'd1;
          if (i == 2'd3) begin
            idx_nxt = 5'd0;
            if (phase_r == wpsp_pkg::PH_RSIZE) begin
              if (rem_new == 32'd0) begin
                e = 1'b1; ec = wpsp_pkg::ERR_RSIZE;
              end else phase_nxt = wpsp_pkg::PH_WAVE;
            end else if (ct_r == wpsp_pkg::CT_FMT) begin
              if (rem_new != 32'd16 && rem_new != 32'd18 && rem_new != 32'd40) begin
                e = 1'b1; ec = wpsp_pkg::ERR_FSIZE;
              end else phase_nxt = wpsp_pkg::PH_FMT;
            end else if (ct_r == wpsp_pkg::CT_DATA) begin
              if (!fseen_r) begin
                e = 1'b1; ec = wpsp_pkg::ERR_NOFMT;
              end else if (tag_r != 16'd1) begin
                e = 1'b1; ec = wpsp_pkg::ERR_PCM;
              end else if (span_now == 18'h3FFFF || bb_r == 16'd0 ||
                           span_now > {2'b00, bb_r}) begin
                e = 1'b1; ec = wpsp_pkg::ERR_BITS;
              end else begin
                clr_nxt = 1'b1; bpos_nxt = 16'd0; span_nxt = span_now;
                phase_nxt = (rem_new == 32'd0) ? wpsp_pkg::PH_CID : wpsp_pkg::PH_DATA;
              end
            end else begin
              phase_nxt = (rem_new == 32'd0) ? wpsp_pkg::PH_CID : wpsp_pkg::PH_SKIP;
            end
          end
        end
        wpsp_pkg::PH_CID: begin
          if (i == 2'd0)
            ct_nxt = (in_byte == 8'h66) ? wpsp_pkg::CT_FMT :
                     (in_byte == 8'h64) ? wpsp_pkg::CT_DATA : wpsp_pkg::CT_OTHER;
          else if (ct_r != wpsp_pkg::CT_OTHER && in_byte != wpsp_pkg::id_byte(ct_r, i))
            ct_nxt = wpsp_pkg::CT_OTHER;
          idx_nxt = {3'd0, i} + 5'd1;
          if (i == 2'd3) begin
            phase_nxt = wpsp_pkg::PH_CSIZE; idx_nxt = 5'd0; rem_nxt = 32'd0;
          end
        end
        wpsp_pkg::PH_FMT: begin
          case (idx_r)
            5'd0: tag_nxt[7:0] = in_byte;
            5'd1: tag_nxt[15:8] = in_byte;
            5'd2: nch_nxt[7:0] = in_byte;
            5'd3: nch_nxt[15:8] = in_byte;
            5'd12: bb_nxt[7:0] = in_byte;
            5'd13: bb_nxt[15:8] = in_byte;
            5'd14: bits_nxt[7:0] = in_byte;
            5'd15: bits_nxt[15:8] = in_byte;
            5'd16: hold_nxt = in_byte;
            5'd17: begin
              if ({in_byte, hold_r} != 16'd0 && {in_byte, hold_r} != 16'd22) begin
                e = 1'b1; ec = wpsp_pkg::ERR_EXT;
              end
            end
            default: ;
          endcase
          if (!e) begin
            // the low-byte offsets 0, 2, 12 and 14 write the whole field, clearing the high byte
            case (idx_r)
              5'd0: tag_nxt[15:8] = 8'd0;
              5'd2: nch_nxt[15:8] = 8'd0;
              5'd12: bb_nxt[15:8] = 8'd0;
              5'd14: bits_nxt[15:8] = 8'd0;
              default: ;
            endcase
            idx_nxt = (idx_r == 5'd31) ? idx_r : idx_r + 5'd1;
            rem_nxt = rem_dec;
            if (rem_dec == 32'd0) begin
              fseen_nxt = 1'b1; phase_nxt = wpsp_pkg::PH_CID; idx_nxt = 5'd0;
            end
          end
        end
        wpsp_pkg::PH_DATA: begin
          if ({2'b00, bpos_r} < span_r) begin
            if (bits_r != 16'd16) begin
              s = 1'b1; sraw = {8'd0, in_byte}; schan = bpos_r;
            end else if (bpos_r[0]) begin
              s = 1'b1; sraw = {in_byte, hold_r}; schan = {1'b0, bpos_r[15:1]};
            end else hold_nxt = in_byte;
          end
          bpos_nxt = (bpos_inc >= {1'b0, bb_r}) ? 16'd0 : bpos_inc[15:0];
          rem_nxt = rem_dec;
          if (rem_dec == 32'd0 && bpos_nxt == 16'd0) begin
            phase_nxt = wpsp_pkg::PH_CID; idx_nxt = 5'd0;
          end
          if (s) clr_nxt = 1'b0;
        end
        wpsp_pkg::PH_SKIP: begin
          rem_nxt = rem_dec;
          if (rem_dec == 32'd0) begin
            phase_nxt = wpsp_pkg::PH_CID; idx_nxt = 5'd0;
          end
        end
        default: begin
          phase_nxt = wpsp_pkg::PH_CID; idx_nxt = 5'd0;
        end
      endcase
      if (e) halt_nxt = 1'b1;
    end
  end

  assign op_valid = e || s;
  assign op.is_err = e;
  assign op.clear = clr_r;
  assign op.code = e ? ec : wpsp_pkg::ERR_RIFF;
  assign op.wide = (bits_r == 16'd16);
  assign op.raw = sraw;
  assign op.chan = schan;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= wpsp_pkg::PH_RIFF; idx_r <= 5'd0; ct_r <= wpsp_pkg::CT_OTHER;
      fseen_r <= 1'b0; tag_r <= 16'd0; nch_r <= 16'd0; bits_r <= 16'd0; bb_r <= 16'd0;
      bpos_r <= 16'd0; rem_r <= 32'd0; hold_r <= 8'd0; halt_r <= 1'b0; clr_r <= 1'b0;
      span_r <= 18'd0;
    end else begin
      phase_r <= phase_nxt; idx_r <= idx_nxt; ct_r <= ct_nxt; fseen_r <= fseen_nxt;
      tag_r <= tag_nxt; nch_r <= nch_nxt; bits_r <= bits_nxt; bb_r <= bb_nxt;
      bpos_r <= bpos_nxt; rem_r <= rem_nxt; hold_r <= hold_nxt; halt_r <= halt_nxt;
      clr_r <= clr_nxt; span_r <= span_nxt;
    end
  end
endmodule

@@ sv/wpsp_queue.sv @@
// Short FIFO of classified ops between front and back.
module wpsp_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  wpsp_pkg::op_t wr_op,
  output logic          room,
  output logic          rd_valid,
  output wpsp_pkg::op_t rd_op,
  input  logic          rd_en
);
  wpsp_pkg::op_t mem_r [wpsp_pkg::QDEPTH];
  logic [wpsp_pkg::QAW-1:0] wp_r, rp_r;
  logic [wpsp_pkg::QAW:0]   cnt_r;

  // keep one slot spare so room is a register-only decision
  assign room = cnt_r < (wpsp_pkg::QAW+1)'(wpsp_pkg::QDEPTH - 1);
  assign rd_valid = cnt_r != '0;
  assign rd_op = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (wpsp_pkg::QAW+1)'(wr_en) - (wpsp_pkg::QAW+1)'(rd_en);
    end
  end
endmodule

@@ sv/wpsp_back.sv @@
// Back end: running statistics and registered result stage.
module wpsp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           op_valid,
  input  wpsp_pkg::op_t  op,
  output logic           op_take,
  output logic           out_valid,
  output wpsp_pkg::res_t res,
  input  logic           out_ready
);
  logic [31:0] cnt_r;
  logic signed [15:0] smin_r, smax_r;
  logic [15:0] umin_r, umax_r;
  logic signed [47:0] ssum_r;
  logic [47:0] usum_r;
  logic valid_r;
  wpsp_pkg::res_t res_r;

  logic [31:0] c0, cn;
  logic signed [15:0] smin0, smax0, sv, sminn, smaxn;
  logic [15:0] umin0, umax0, uminn, umaxn;
  logic signed [47:0] ssum0, ssumn;
  logic signed [48:0] st;
  logic [47:0] usum0, usumn;
  logic [48:0] ut;

  assign op_take = op_valid && (!valid_r || out_ready);

  always_comb begin
    c0 = op.clear ? 32'd0 : cnt_r;
    smin0 = op.clear ? 16'sh7FFF : smin_r;
    smax0 = op.clear ? -16'sh8000 : smax_r;
    umin0 = op.clear ? 16'hFFFF : umin_r;
    umax0 = op.clear ? 16'h0000 : umax_r;
    ssum0 = op.clear ? 48'sd0 : ssum_r;
    usum0 = op.clear ? 48'd0 : usum_r;
    sv = op.wide ? $signed(op.raw) : $signed({8'd0, op.raw[7:0]});
    cn = (c0 == 32'hFFFFFFFF) ? c0 : c0 + 32'd1;
    sminn = (sv < smin0) ? sv : smin0;
    smaxn = (sv > smax0) ? sv : smax0;
    uminn = (op.raw < umin0) ? op.raw : umin0;
    umaxn = (op.raw > umax0) ? op.raw : umax0;
    st = {ssum0[47], ssum0} + {{33{sv[15]}}, sv};
    ssumn = (st[48] != st[47]) ? (st[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}})
                               : st[47:0];
    ut = {1'b0, usum0} + {33'd0, op.raw};
    usumn = ut[48] ? {48{1'b1}} : ut[47:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r <= 32'd0; smin_r <= 16'sh7FFF; smax_r <= -16'sh8000;
      umin_r <= 16'hFFFF; umax_r <= 16'h0000; ssum_r <= 48'sd0; usum_r <= 48'd0;
    end else begin
      if (op_take) valid_r <= 1'b1;
      else if (out_ready) valid_r <= 1'b0;
      if (op_take && !op.is_err) begin
        cnt_r <= cn; smin_r <= sminn; smax_r <= smaxn;
        umin_r <= uminn; umax_r <= umaxn; ssum_r <= ssumn; usum_r <= usumn;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op_take) begin
      if (op.is_err) begin
        res_r.kind <= 1'b1;
        res_r.error_code <= op.code;
        res_r.sample_raw <= 16'd0;
        res_r.channel <= 16'd0;
        res_r.sample_count <= 32'd0;
        res_r.signed_min <= 16'd0;
        res_r.signed_max <= 16'd0;
        res_r.unsigned_min <= 16'd0;
        res_r.unsigned_max <= 16'd0;
        res_r.signed_total <= 48'd0;
        res_r.unsigned_total <= 48'd0;
      end else begin
        res_r.kind <= 1'b0;
        res_r.error_code <= wpsp_pkg::ERR_RIFF;
        res_r.sample_raw <= op.raw;
        res_r.channel <= op.chan;
        res_r.sample_count <= cn;
        res_r.signed_min <= sminn;
        res_r.signed_max <= smaxn;
        res_r.unsigned_min <= uminn;
        res_r.unsigned_max <= umaxn;
        res_r.signed_total <= ssumn;
        res_r.unsigned_total <= usumn;
      end
    end
  end

  assign out_valid = valid_r;
  assign res = res_r;
endmodule

@@ sv/wav_pcm_stream_parser_stats_core.sv @@
// Top level of the RIFF/WAVE PCM parser with sample statistics.
// Throughput: one byte per cycle while the result side keeps up.
// On its way from its byte, a result is registered first in the op queue, then in the result register.
// The front stalls only when the 4-entry op queue holds 3 ops.
// After an error the block takes and discards every byte until reset.
// Reset: synchronous, active low, returns the parser to the RIFF magic.
module wav_pcm_stream_parser_stats_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // in_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [231:0] out_tdata   // kind, error_code, sample_raw, channel, sample_count,
                                   // signed_min, signed_max, unsigned_min, unsigned_max,
                                   // signed_total, unsigned_total, 4 bits zero fill
);
  logic           f_valid, q_room, q_valid, q_take;
  wpsp_pkg::op_t  f_op, q_op;
  wpsp_pkg::res_t r;

  wpsp_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_byte(in_tdata),
    .in_ready(in_tready), .op_valid(f_valid), .op(f_op), .op_room(q_room)
  );

  wpsp_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_en(f_valid), .wr_op(f_op), .room(q_room),
    .rd_valid(q_valid), .rd_op(q_op), .rd_en(q_take)
  );

  wpsp_back u_back (
    .clk(clk), .rst_n(rst_n), .op_valid(q_valid), .op(q_op), .op_take(q_take),
    .out_valid(out_tvalid), .res(r), .out_ready(out_tready)
  );

  assign out_tdata = {4'd0, r.unsigned_total, r.signed_total, r.unsigned_max,
                      r.unsigned_min, r.signed_max, r.signed_min, r.sample_count,
                      r.channel, r.sample_raw, r.error_code, r.kind};
endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the RIFF/WAVE PCM parser with sample statistics.
module testbench;
  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [231:0] out_tdata;

  wav_pcm_stream_parser_stats_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // file image and the results it should produce
  logic [7:0] file_bytes[$];
  logic [15:0] known_raws[$];
  wpsp_pkg::res_t expected_results[$];
  int         failures = 0;
  int         cycles = 0;
  int         idle_in_pct = 9;
  int         idle_out_pct = 50;
  bit         holdoff_req = 0;

  // parser shadow state
  logic [3:0]  ph;
  logic [31:0] fidx, ashift, remain;
  logic [1:0]  ctype;
  bit          fmt_seen, halt;
  logic [15:0] ftag, nchan, nbits, blk, bpos;
  logic [7:0]  lowb;
  logic [31:0] scount;
  int          smin, smax, umin, umax;
  longint      ssum, usum;

  localparam logic [7:0] RIFF_ID[4] = '{8'h52, 8'h49, 8'h46, 8'h46};
  localparam logic [7:0] WAVE_ID[4] = '{8'h57, 8'h41, 8'h56, 8'h45};
  localparam logic [7:0] FMT_ID[4]  = '{8'h66, 8'h6D, 8'h74, 8'h20};
  localparam logic [7:0] DATA_ID[4] = '{8'h64, 8'h61, 8'h74, 8'h61};

  task automatic clear_stats();
    scount = 0; smin = 32767; smax = -32768; umin = 65535; umax = 0;
    ssum = 0; usum = 0;
  endtask

  task automatic flag_error(input logic [2:0] code, output bit got,
                            output wpsp_pkg::res_t r);
    r = '0;
    r.kind = 1'b1;
    r.error_code = code;
    got = 1;
    halt = 1;
  endtask

  task automatic tally_sample(input int raw, input int chan, output bit got,
                              output wpsp_pkg::res_t r);
    int sv;
    sv = (nbits == 16 && raw >= 32768) ? raw - 65536 : raw;
    if (scount != 32'hFFFF_FFFF) scount++;
    if (sv < smin) smin = sv;
    if (sv > smax) smax = sv;
    if (raw < umin) umin = raw;
    if (raw > umax) umax = raw;
    ssum = ssum + sv;
    if (ssum > 64'sd140737488355327) ssum = 64'sd140737488355327;
    if (ssum < -64'sd140737488355328) ssum = -64'sd140737488355328;
    usum = usum + raw;
    if (usum > 64'sd281474976710655) usum = 64'sd281474976710655;
    r = '0;
    r.sample_raw = raw[15:0];
    r.channel = chan[15:0];
    r.sample_count = scount;
    r.signed_min = smin[15:0];
    r.signed_max = smax[15:0];
    r.unsigned_min = umin[15:0];
    r.unsigned_max = umax[15:0];
    r.signed_total = ssum[47:0];
    r.unsigned_total = usum[47:0];
    got = 1;
  endtask

  task automatic parser_reset();
    ph = wpsp_pkg::PH_RIFF; fidx = 0; ashift = 0; ctype = wpsp_pkg::CT_OTHER;
    fmt_seen = 0;
    ftag = 0; nchan = 0; nbits = 0; blk = 0; bpos = 0; remain = 0; lowb = 0;
    halt = 0;
    clear_stats();
  endtask

  task automatic parse_byte(input logic [7:0] b, output bit got, output wpsp_pkg::res_t r);
    logic [1:0] i;
    int bps, p;
    i = fidx[1:0];
    got = 0;
    r = '0;
    if (halt) return;
    case (ph)
      wpsp_pkg::PH_RIFF, wpsp_pkg::PH_WAVE: begin
        if (b != (ph == wpsp_pkg::PH_RIFF ? RIFF_ID[i] : WAVE_ID[i])) begin
          flag_error(ph == wpsp_pkg::PH_RIFF ? wpsp_pkg::ERR_RIFF : wpsp_pkg::ERR_WAVE,
                     got, r);
          return;
        end
        fidx = i + 1;
        if (i == 3) begin
          fidx = 0;
          if (ph == wpsp_pkg::PH_RIFF) begin
            ph = wpsp_pkg::PH_RSIZE; remain = 0; ashift = 0;
          end else ph = wpsp_pkg::PH_CID;
        end
      end
      wpsp_pkg::PH_RSIZE, wpsp_pkg::PH_CSIZE: begin
        remain = remain | (32'(b) << ashift[4:0]);
        ashift = (ashift + 8) & 31;
        fidx = i + 1;
        if (i == 3) begin
          fidx = 0;
          if (ph == wpsp_pkg::PH_RSIZE) begin
            if (remain == 0) flag_error(wpsp_pkg::ERR_RSIZE, got, r);
            else ph = wpsp_pkg::PH_WAVE;
          end else if (ctype == wpsp_pkg::CT_FMT) begin
            if (remain != 16 && remain != 18 && remain != 40)
              flag_error(wpsp_pkg::ERR_FSIZE, got, r);
            else ph = wpsp_pkg::PH_FMT;
          end else if (ctype == wpsp_pkg::CT_DATA) begin
            if (!fmt_seen) flag_error(wpsp_pkg::ERR_NOFMT, got, r);
            else if (ftag != 1) flag_error(wpsp_pkg::ERR_PCM, got, r);
            else if ((nbits != 8 && nbits != 16) || blk == 0 ||
                     32'(nchan) * 32'(nbits >> 3) > 32'(blk))
              flag_error(wpsp_pkg::ERR_BITS, got, r);
            else begin
              clear_stats();
              bpos = 0;
              ph = (remain == 0) ? wpsp_pkg::PH_CID : wpsp_pkg::PH_DATA;
            end
          end else ph = (remain == 0) ? wpsp_pkg::PH_CID : wpsp_pkg::PH_SKIP;
        end
      end
      wpsp_pkg::PH_CID: begin
        if (i == 0)
          ctype = (b == FMT_ID[0]) ? wpsp_pkg::CT_FMT :
                  (b == DATA_ID[0]) ? wpsp_pkg::CT_DATA : wpsp_pkg::CT_OTHER;
        else if (ctype == wpsp_pkg::CT_FMT && b != FMT_ID[i]) ctype = wpsp_pkg::CT_OTHER;
        else if (ctype == wpsp_pkg::CT_DATA && b != DATA_ID[i]) ctype = wpsp_pkg::CT_OTHER;
        fidx = i + 1;
        if (i == 3) begin
          ph = wpsp_pkg::PH_CSIZE; fidx = 0; remain = 0; ashift = 0;
        end
      end
      wpsp_pkg::PH_FMT: begin
        if (fidx == 0) ftag = {8'h00, b};
        else if (fidx == 1) ftag[15:8] = b;
        else if (fidx == 2) nchan = {8'h00, b};
        else if (fidx == 3) nchan[15:8] = b;
        else if (fidx == 12) blk = {8'h00, b};
        else if (fidx == 13) blk[15:8] = b;
        else if (fidx == 14) nbits = {8'h00, b};
        else if (fidx == 15) nbits[15:8] = b;
        else if (fidx == 16) lowb = b;
        else if (fidx == 17 && {b, lowb} != 0 && {b, lowb} != 22) begin
          flag_error(wpsp_pkg::ERR_EXT, got, r);
          return;
        end
        fidx++;
        if (remain != 0) remain--;
        if (remain == 0) begin
          fmt_seen = 1; ph = wpsp_pkg::PH_CID; fidx = 0;
        end
      end
      wpsp_pkg::PH_DATA: begin
        bps = nbits >> 3;
        if (bps == 0) bps = 1;
        p = bpos;
        if (p < nchan * bps) begin
          if (bps == 1) tally_sample(b, p, got, r);
          else if (p & 1) tally_sample({b, lowb}, p >> 1, got, r);
          else lowb = b;
        end
        bpos = p + 1;
        if (bpos >= blk) bpos = 0;
        if (remain != 0) remain--;
        if (remain == 0 && bpos == 0) begin
          ph = wpsp_pkg::PH_CID; fidx = 0;
        end
      end
      wpsp_pkg::PH_SKIP: begin
        if (remain != 0) remain--;
        if (remain == 0) begin
          ph = wpsp_pkg::PH_CID; fidx = 0;
        end
      end
      default: begin
        ph = wpsp_pkg::PH_CID; fidx = 0;
      end
    endcase
  endtask

  // file image builders
  task automatic put16(input int v);
    file_bytes.push_back(v[7:0]);
    file_bytes.push_back(v[15:8]);
  endtask

  task automatic put32(input logic [31:0] v);
    for (int k = 0; k < 4; k++) file_bytes.push_back(v[8*k +: 8]);
  endtask

  task automatic put_id(input logic [7:0] id[4]);
    for (int k = 0; k < 4; k++) file_bytes.push_back(id[k]);
  endtask

  task automatic put_fmt(input int size, input int tag, input int ch, input int bl,
                         input int bits, input int ext);
    put_id(FMT_ID);
    put32(size);
    put16(tag); put16(ch);
    put32($urandom); put32($urandom);
    put16(bl); put16(bits);
    if (size > 16) put16(ext);
    for (int k = 18; k < size; k++) file_bytes.push_back($urandom_range(0, 255));
  endtask

  task automatic put_data(input int size, input int bl);
    int n;
    put_id(DATA_ID);
    put32(size);
    n = (size == 0) ? 0 : ((size + bl - 1) / bl) * bl;
    for (int k = 0; k < n; k++) file_bytes.push_back($urandom_range(0, 255));
  endtask

  task automatic put_other();
    logic [7:0] id[4];
    int size;
    case ($urandom_range(0, 3))
      0: id = '{8'h66, 8'h6D, 8'h74, 8'h58};  // fmt id broken at the last byte
      1: id = '{8'h64, 8'h61, 8'h74, 8'h20};  // data id broken at the last byte
      2: id = '{8'h66, 8'h61, 8'h74, 8'h61};
      default: begin
        foreach (id[k]) id[k] = $urandom_range(0, 255);
        if (id[0] == 8'h66 || id[0] == 8'h64) id[0] = 8'h4C;
      end
    endcase
    put_id(id);
    size = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 24);
    put32(size);
    for (int k = 0; k < size; k++) file_bytes.push_back($urandom_range(0, 255));
  endtask

  // good PCM format followed by a data chunk
  task automatic put_pcm_pair();
    int bits, ch, bl, fsz;
    bits = $urandom_range(0, 1) ? 16 : 8;
    ch = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
    bl = ch * (bits / 8) + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
    if (bl == 0) bl = 1;
    case ($urandom_range(0, 2))
      0: fsz = 16;
      1: fsz = 18;
      default: fsz = 40;
    endcase
    put_fmt(fsz, 1, ch, bl, bits, $urandom_range(0, 1) ? 0 : 22);
    put_data(($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 40), bl);
  endtask

  typedef struct {
    logic [7:0]  b;
    bit          known;
    logic [15:0] raw;
  } stim_row_t;

  // 16-bit stereo header, four extreme samples
  stim_row_t directed[20] = '{
    '{8'h52, 0, 0}, '{8'h49, 0, 0}, '{8'h46, 0, 0}, '{8'h46, 0, 0},
    '{8'hFF, 0, 0}, '{8'hFF, 0, 0}, '{8'hFF, 0, 0}, '{8'hFF, 0, 0},
    '{8'h57, 0, 0}, '{8'h41, 0, 0}, '{8'h56, 0, 0}, '{8'h45, 0, 0},
    '{8'h00, 1, 16'h0000}, '{8'h00, 0, 0}, '{8'hFF, 1, 16'hFFFF}, '{8'hFF, 0, 0},
    '{8'h00, 1, 16'h8000}, '{8'h80, 0, 0}, '{8'hFF, 1, 16'h7FFF}, '{8'h7F, 0, 0}
  };

  task automatic build_file();
    int tail;
    for (int k = 0; k < 12; k++) file_bytes.push_back(directed[k].b);
    put_fmt(16, 1, 2, 4, 16, 0);
    put_id(DATA_ID);
    put32(8);
    for (int k = 12; k < $size(directed); k++) begin
      // samples come in byte pairs: the known raw sits on the first byte of each
      file_bytes.push_back(directed[k].b);
      if (directed[k].known) known_raws.push_back(directed[k].raw);
    end
    while (file_bytes.size() < 1700) begin
      case ($urandom_range(0, 9))
        0, 1: put_other();
        2: begin
          // unusable format, replaced before any data
          put_fmt(16, $urandom_range(0, 1) ? 3 : 65535, 1, 1,
                  $urandom_range(0, 1) ? 24 : 8, 0);
          put_pcm_pair();
        end
        default: put_pcm_pair();
      endcase
    end
    tail = $urandom_range(0, 4);
    case (tail)
      0: begin
        put_id(FMT_ID); put32(20);
      end
      1: put_fmt(18, 1, 1, 1, 8, $urandom_range(1, 21));
      2: begin
        put_fmt(16, 3, 1, 2, 16, 0); put_id(DATA_ID); put32(4);
      end
      3: begin
        put_fmt(16, 1, 1, 2, 12, 0); put_id(DATA_ID); put32(4);
      end
      default: begin
        put_fmt(16, 1, 4, 3, 8, 0); put_id(DATA_ID); put32(4);
      end
    endcase
  endtask

  // scoreboard side
  always @(posedge clk) begin
    bit   got;
    wpsp_pkg::res_t r;
    logic [231:0] a;
    longint ef[11], af[11];
    cycles <= cycles + 1;
    if (rst_n && in_tvalid && in_tready) begin
      parse_byte(in_tdata, got, r);
      if (got) expected_results.push_back(r);
    end
    if (rst_n && out_tvalid && out_tready) begin
      a = out_tdata;
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected, actual %h", $realtime, out_tdata);
        failures++;
      end else begin
        r = expected_results.pop_front();
        ef = '{r.kind, r.error_code, r.sample_raw, r.channel, r.sample_count,
               r.signed_min, r.signed_max, r.unsigned_min, r.unsigned_max,
               r.signed_total, r.unsigned_total};
        af = '{a[0], a[3:1], a[19:4], a[35:20], a[67:36], a[83:68], a[99:84],
               a[115:100], a[131:116], a[179:132], a[227:180]};
        for (int k = 0; k < 11; k++)
          if (ef[k] != af[k]) begin
            $display("%0t: field %0d expected %h actual %h", $realtime, k, ef[k], af[k]);
            failures++;
          end
        if (!r.kind && known_raws.size() > 0) begin
          if (known_raws[0] != a[19:4]) begin
            $display("%0t: directed sample expected %h actual %h",
                     $realtime, known_raws[0], a[19:4]);
            failures++;
          end
          void'(known_raws.pop_front());
        end
      end
    end
    if (cycles > 200000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_req) begin
        out_tready <= 1'b0;
        holdoff_req = 0;
        repeat (150) @(negedge clk);
      end
      out_tready <= ($urandom_range(0, 99) >= idle_out_pct);
    end
  end

  // sender
  initial begin
    int n;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'h00;
    parser_reset();
    build_file();
    n = file_bytes.size();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int k = 0; k < n; k++) begin
      if (halt) break;
      if (k == n / 3) begin
        idle_in_pct = 50; idle_out_pct = 9;
      end
      if (k == 2 * n / 3) begin
        idle_in_pct = 0; idle_out_pct = 0;
      end
      if (k == 300) holdoff_req = 1;
      if (k == 1000) begin
        in_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(negedge clk);
      end
      while ($urandom_range(0, 99) < idle_in_pct) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata <= file_bytes[k];
      do @(posedge clk); while (!in_tready);
      @(negedge clk);
    end
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (failures == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
